>>> src/whole_word_replacer_top_defines.svh
// Assertion macros for the whole word replacer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef WHOLE_WORD_REPLACER_TOP_DEFINES_SVH
`define WHOLE_WORD_REPLACER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WWR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wwr assertion failed");
`define WWR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wwr assertion failed");
`else
`define WWR_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define WWR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> src/wwr_pkg.sv
// Package for the whole word replacer: widths, register indexes, config struct.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wwr_pkg;

    localparam int unsigned MAX_WORD_DEF = 8;
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned WORD_W       = 64;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_WORD = 2'd0,
        CFG_TARGET_LEN  = 2'd1,
        CFG_REPL_WORD   = 2'd2,
        CFG_REPL_LEN    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] target_word;
        logic [LEN_W-1:0]  target_len;
        logic [WORD_W-1:0] replacement_word;
        logic [LEN_W-1:0]  replacement_len;
    } t_cfg;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > max_len) begin
            r = max_len;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/wwr_cfg.sv
// Configuration registers of the whole word replacer.
// Depends on wwr_pkg.
`timescale 1ns / 1ps

module wwr_cfg import wwr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_word      <= '0;
            r_cfg.target_len       <= LEN_W'(1);
            r_cfg.replacement_word <= '0;
            r_cfg.replacement_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_WORD: r_cfg.target_word      <= i_cfg_data;
                CFG_TARGET_LEN:  r_cfg.target_len       <= i_cfg_data[LEN_W-1:0];
                CFG_REPL_WORD:   r_cfg.replacement_word <= i_cfg_data;
                CFG_REPL_LEN:    r_cfg.replacement_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/wwr_match.sv
// Input register, candidate word tracking and output run builder.
// Depends on wwr_pkg; feeds wwr_run.
`timescale 1ns / 1ps

module wwr_match import wwr_pkg::*; #(
    parameter int unsigned MAX_WORD = MAX_WORD_DEF,
    localparam int unsigned RunW    = $clog2(MAX_WORD + 2)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [CHAR_W-1:0]              i_s_char,
    input  logic                           i_s_last,
    input  logic                           i_run_free,
    output logic                           o_load,
    output logic [MAX_WORD:0][CHAR_W-1:0]  o_load_chars,
    output logic [RunW-1:0]                o_load_len,
    output logic                           o_load_line
);

    localparam int unsigned CntW = $clog2(MAX_WORD + 1);
    localparam int unsigned IdxW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    logic                              r_in_valid;
    logic [CHAR_W-1:0]                 r_in_char;
    logic                              r_in_last;
    logic [MAX_WORD-1:0][CHAR_W-1:0]   r_held;
    logic [CntW-1:0]                   r_hc;
    logic                              r_pt;
    logic [CntW-1:0]                   n_hc;
    logic                              n_pt;

    logic                              proc;
    logic                              is_space;
    logic [CntW-1:0]                   tl;
    logic [CntW-1:0]                   rl;
    logic [CntW-1:0]                   hc_inc;
    logic [IdxW-1:0]                   hc_idx;
    logic [CHAR_W-1:0]                 want;
    logic                              hit;
    logic                              quiet;
    logic                              use_rep;
    logic                              has_tail;
    logic [CntW-1:0]                   plen;

    assign proc       = r_in_valid & i_run_free;
    assign o_s_tready = ~r_in_valid | i_run_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_char;
            r_in_last <= i_s_last;
        end
    end

    assign tl       = CntW'(clamp_len(i_cfg.target_len, LEN_W'(MAX_WORD)));
    assign rl       = CntW'(clamp_len(i_cfg.replacement_len, LEN_W'(MAX_WORD)));
    assign is_space = (r_in_char == SPACE_CHAR);
    assign hc_inc   = r_hc + CntW'(1);
    assign hc_idx   = r_hc[IdxW-1:0];
    assign want     = CHAR_W'(i_cfg.target_word >> {hc_idx, 3'b000});
    assign hit      = ~is_space & ~r_pt & (r_hc < tl) & (r_in_char == want);
    // a matching character mid-sentence is only held back
    assign quiet    = hit & ~r_in_last;
    assign use_rep  = is_space ? (~r_pt & (r_hc == tl)) : (hit & r_in_last & (hc_inc == tl));
    assign plen     = quiet ? '0 : (use_rep ? rl : r_hc);
    assign has_tail = ~quiet & (is_space | ~use_rep);

    always_comb begin
        for (int i = 0; i <= MAX_WORD; i++) begin
            o_load_chars[i] = r_in_char;
            if (i < MAX_WORD) begin
                if (CntW'(i) < plen) begin
                    o_load_chars[i] = use_rep ? i_cfg.replacement_word[CHAR_W*i +: CHAR_W]
                                              : r_held[i];
                end
            end
        end
    end

    assign o_load_len  = RunW'(plen) + RunW'(has_tail);
    assign o_load      = proc & (o_load_len != '0);
    assign o_load_line = r_in_last;

    always_comb begin
        n_hc = r_hc;
        n_pt = r_pt;
        if (is_space || r_in_last) begin
            n_hc = '0;
            n_pt = 1'b0;
        end else if (!r_pt) begin
            if (hit) begin
                n_hc = hc_inc;
            end else begin
                n_hc = '0;
                n_pt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= '0;
            r_pt <= 1'b0;
        end else if (proc) begin
            r_hc <= n_hc;
            r_pt <= n_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && quiet) begin
            r_held[hc_idx] <= r_in_char;
        end
    end

endmodule

>>> src/wwr_run.sv
// Result run buffer: holds one run of characters and shifts it out.
// Depends on wwr_pkg and whole_word_replacer_top_defines.svh.
`timescale 1ns / 1ps
`include "whole_word_replacer_top_defines.svh"

module wwr_run import wwr_pkg::*; #(
    parameter int unsigned MAX_WORD = MAX_WORD_DEF,
    localparam int unsigned RunW    = $clog2(MAX_WORD + 2)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [MAX_WORD:0][CHAR_W-1:0]  i_load_chars,
    input  logic [RunW-1:0]                i_load_len,
    input  logic                           i_load_line,
    output logic                           o_free,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [CHAR_W-1:0]              o_m_char,
    output logic                           o_m_last,
    output logic                           o_m_line
);

    logic [MAX_WORD:0][CHAR_W-1:0] r_run;
    logic [RunW-1:0]               r_rem;
    logic                          r_line;
    logic                          take;

    assign take   = (r_rem != '0) & i_m_tready;
    assign o_free = (r_rem == '0) | ((r_rem == RunW'(1)) & i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_line <= 1'b0;
        end else if (i_load) begin
            r_rem  <= i_load_len;
            r_line <= i_load_line;
        end else if (take) begin
            r_rem  <= r_rem - RunW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_load_chars;
        end else if (take) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                r_run[i] <= r_run[i+1];
            end
        end
    end

    assign o_m_tvalid = (r_rem != '0);
    assign o_m_char   = r_run[0];
    assign o_m_last   = (r_rem == RunW'(1));
    assign o_m_line   = r_line & (r_rem == RunW'(1));

    `WWR_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, i_load, o_free)
    `WWR_ASSERT_NEXT(a_load_len, i_clk, i_rst_n, i_load, r_rem == $past(i_load_len))
    `WWR_ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n, 1'b1, r_rem <= RunW'(MAX_WORD + 1))
    `WWR_ASSERT_NEXT(a_drain, i_clk, i_rst_n, take && !i_load, r_rem == $past(r_rem) - RunW'(1))

endmodule

>>> src/whole_word_replacer_top.sv
// Top level of the whole word replacer: config registers, matcher, run buffer.
// Depends on wwr_pkg, wwr_cfg, wwr_match and wwr_run.
//
// Usage: characters enter on the s_axis channel (tdata = character,
// tlast = final character of the sentence). Rewritten characters leave on
// m_axis, one per transaction: tlast marks the last character caused by an
// input character, tuser[0] the final character of the rewritten sentence.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// The first result passes through the input register and the run buffer
// before it is offered. Throughput: one character per cycle while m_axis
// is ready and each input yields at most one result; an input that yields
// a run of results (a flush or a replacement at a word end) holds the input
// until its last result is taken from the single run buffer, which shifts
// out one character per cycle while m_axis is ready. Held characters yield
// nothing. Reset clears the input register, run buffer and word state and
// sets both lengths to one. When m_axis stalls, the run buffer holds, one
// further input is kept in the input register and s_axis_tready then drops.
`timescale 1ns / 1ps

module whole_word_replacer_top import wwr_pkg::*; #(
    parameter int unsigned MAX_WORD = MAX_WORD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] in_char
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] out_char
    output logic                 m_axis_tlast,
    output logic [0:0]           m_axis_tuser   // [0] line_done
);

    localparam int unsigned RunW = $clog2(MAX_WORD + 2);

    t_cfg                          cfg;
    logic                          run_free;
    logic                          load;
    logic [MAX_WORD:0][CHAR_W-1:0] load_chars;
    logic [RunW-1:0]               load_len;
    logic                          load_line;
    logic                          m_line;

    wwr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wwr_match #(.MAX_WORD(MAX_WORD)) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_char     (s_axis_tdata),
        .i_s_last     (s_axis_tlast),
        .i_run_free   (run_free),
        .o_load       (load),
        .o_load_chars (load_chars),
        .o_load_len   (load_len),
        .o_load_line  (load_line)
    );

    wwr_run #(.MAX_WORD(MAX_WORD)) u_run (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_load_chars (load_chars),
        .i_load_len   (load_len),
        .i_load_line  (load_line),
        .o_free       (run_free),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_char     (m_axis_tdata),
        .o_m_last     (m_axis_tlast),
        .o_m_line     (m_line)
    );

    assign m_axis_tuser = m_line;

endmodule

>>> sim/whole_word_replacer_top_tb.sv
// Self-checking testbench for whole_word_replacer_top: streams sentences, predicts the rewrite.
// Depends on wwr_pkg and the whole_word_replacer_top RTL; needs no files or arguments.
`timescale 1ns / 1ps

module whole_word_replacer_top_tb;
    import wwr_pkg::*;

    localparam int unsigned WORD_CHARS  = MAX_WORD_DEF;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_end;
    } t_char_in;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_last;
        logic              line_done;
    } t_rewrite_out;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [WORD_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // [7:0] in_char
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // [7:0] out_char
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;        // [0] line_done

    whole_word_replacer_top i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of registers and word state
    logic [WORD_W-1:0] tgt_word  = '0;
    logic [LEN_W-1:0]  tgt_len   = LEN_W'(1);
    logic [WORD_W-1:0] repl_word = '0;
    logic [LEN_W-1:0]  repl_len  = LEN_W'(1);
    logic [CHAR_W-1:0] held_chars [WORD_CHARS];
    int unsigned       held_n       = 0;
    logic              word_passing = 1'b0;

    t_char_in     char_queue[$];
    t_rewrite_out expected_chars[$];
    t_rewrite_out step_out[$];

    int unsigned idle_pct      = 12;
    int unsigned results_seen  = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    logic        in_taken      = 1'b0;

    function automatic int unsigned eff_len(logic [LEN_W-1:0] v);
        if (v == '0) return 1;
        if (v > WORD_CHARS) return WORD_CHARS;
        return v;
    endfunction

    function automatic void emit_char(logic [CHAR_W-1:0] c);
        step_out.push_back('{ch: c, run_last: 1'b0, line_done: 1'b0});
    endfunction

    function automatic void flush_held();
        for (int unsigned i = 0; i < held_n; i++) emit_char(held_chars[i]);
        held_n = 0;
    endfunction

    function automatic void close_word();
        int unsigned rl;
        if (!word_passing && held_n == eff_len(tgt_len)) begin
            rl = eff_len(repl_len);
            for (int unsigned i = 0; i < rl; i++) emit_char(repl_word[8*i +: 8]);
            held_n = 0;
        end else begin
            flush_held();
        end
        word_passing = 1'b0;
    endfunction

    function automatic void predict_rewrite(logic [CHAR_W-1:0] c, logic is_end);
        step_out.delete();
        if (c == SPACE_CHAR) begin
            close_word();
            emit_char(c);
        end else begin
            if (word_passing) begin
                emit_char(c);
            end else if (held_n < eff_len(tgt_len) && c == tgt_word[8*held_n +: 8]) begin
                held_chars[held_n] = c;
                held_n++;
            end else begin
                flush_held();
                emit_char(c);
                word_passing = 1'b1;
            end
            if (is_end) close_word();
        end
        if (is_end) begin
            held_n       = 0;
            word_passing = 1'b0;
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].run_last  = 1'b1;
            step_out[step_out.size()-1].line_done = is_end;
        end
        foreach (step_out[i]) expected_chars.push_back(step_out[i]);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_nonspace();
        logic [CHAR_W-1:0] c;
        do c = $urandom_range(0, 255); while (c == SPACE_CHAR);
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word_nonspace();
        logic [WORD_W-1:0] w;
        for (int i = 0; i < WORD_CHARS; i++) w[8*i +: 8] = rand_nonspace();
        return w;
    endfunction

    // words mostly built around the target so that matches, prefixes and overruns occur
    function automatic int unsigned queue_sentence();
        t_char_in          line[$];
        logic [CHAR_W-1:0] w[$];
        logic [CHAR_W-1:0] c;
        int unsigned       nw, tl, kind, n;
        nw = $urandom_range(1, 6);
        tl = eff_len(tgt_len);
        if ($urandom_range(0, 7) == 0) line.push_back('{ch: SPACE_CHAR, is_end: 1'b0});
        for (int unsigned k = 0; k < nw; k++) begin
            w.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                n = (kind == 4 && tl > 1) ? $urandom_range(1, tl - 1) : tl;
                for (int unsigned i = 0; i < n; i++) w.push_back(tgt_word[8*i +: 8]);
                if (kind == 5) w.push_back(rand_nonspace());
                if (kind == 6) begin
                    do c = rand_nonspace(); while (c == w[n-1]);
                    w[n-1] = c;
                end
            end else begin
                n = $urandom_range(1, 10);
                for (int unsigned i = 0; i < n; i++) w.push_back($urandom_range(0, 255));
            end
            foreach (w[i]) line.push_back('{ch: w[i], is_end: 1'b0});
            if (k < nw - 1) begin
                line.push_back('{ch: SPACE_CHAR, is_end: 1'b0});
                if ($urandom_range(0, 4) == 0) line.push_back('{ch: SPACE_CHAR, is_end: 1'b0});
            end
        end
        if ($urandom_range(0, 3) == 0) line.push_back('{ch: SPACE_CHAR, is_end: 1'b1});
        else line[line.size()-1].is_end = 1'b1;
        foreach (line[i]) char_queue.push_back(line[i]);
        return line.size();
    endfunction

    function automatic void queue_text(string s, logic end_sentence);
        for (int i = 0; i < s.len(); i++) begin
            char_queue.push_back('{ch: s[i], is_end: end_sentence && (i == s.len() - 1)});
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [WORD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_TARGET_WORD: tgt_word  = v;
            CFG_TARGET_LEN:  tgt_len   = v[LEN_W-1:0];
            CFG_REPL_WORD:   repl_word = v;
            CFG_REPL_LEN:    repl_len  = v[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [WORD_W-1:0] tw, logic [LEN_W-1:0] tl,
                              logic [WORD_W-1:0] rw, logic [LEN_W-1:0] rl);
        write_reg(CFG_TARGET_WORD, tw);
        write_reg(CFG_TARGET_LEN, WORD_W'(tl));
        write_reg(CFG_REPL_WORD, rw);
        write_reg(CFG_REPL_LEN, WORD_W'(rl));
    endtask

    task automatic wait_idle();
        while (char_queue.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_char_in item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_taken || !s_axis_tvalid) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                item = char_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.ch;
                s_axis_tlast  <= item.is_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off once traffic is under way
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 100) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        t_rewrite_out want;
        logic         out_taken;
        in_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_taken) predict_rewrite(s_axis_tdata, s_axis_tlast);
        if (out_taken) begin
            results_seen++;
            if (expected_chars.size() == 0) begin
                $error("unexpected result: out_char %02h", m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.ch) begin
                    $error("out_char: expected %02h, got %02h", want.ch, m_axis_tdata);
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, m_axis_tlast);
                    mismatch_cnt++;
                end
                if (m_axis_tuser[0] !== want.line_done) begin
                    $error("line_done: expected %0b, got %0b", want.line_done, m_axis_tuser[0]);
                    mismatch_cnt++;
                end
            end
        end
        if (!i_rst_n || in_taken || out_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned queued;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: target is the zero character, replaced by zero
        char_queue.push_back('{ch: 8'h00, is_end: 1'b1});
        char_queue.push_back('{ch: 8'hFF, is_end: 1'b1});
        wait_idle();

        set_config(WORD_W'("tac"), 4'd3, WORD_W'("god"), 4'd3);
        queue_text("cat cats  ca cat", 1'b1);
        queue_text(" ", 1'b1);
        wait_idle();

        // lengths out of range: zero acts as one, fifteen as eight
        set_config(WORD_W'("x"), 4'd0, 64'h4847_4645_4443_4241, 4'd15);
        queue_text("x x", 1'b1);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_config(rand_word_nonspace(), 4'd8,
                              {$urandom, $urandom}, 4'd1);
                1: set_config(rand_word_nonspace(), 4'd1,
                              {WORD_W{1'b1}}, 4'd8);
                2: set_config(rand_word_nonspace(), LEN_W'($urandom_range(0, 15)),
                              {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)));
                default: begin
                    idle_pct = 0;
                    set_config(rand_word_nonspace(), LEN_W'($urandom_range(1, 8)),
                               {$urandom, $urandom}, LEN_W'($urandom_range(1, 8)));
                end
            endcase
            queued = 0;
            while (queued < 55) queued += queue_sentence();
            wait_idle();
        end

        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
